### rtl/xcfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared constants and types for the xor checked frame receiver.
// ----------------------------------------------------------------------------
package xcfr_pkg;

    // largest body length the buffer holds, id byte included
    localparam int MAX_LEN = 32;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    localparam int BYTE_W    = 8;
    localparam int CFG_LEN_W = 6;
    localparam int STATUS_W  = 2;

    // configuration register indexes
    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_MAX_LENGTH = 1'b1;

    localparam logic [BYTE_W-1:0]    START_BYTE_RST = 8'd165;
    localparam logic [CFG_LEN_W-1:0] MAX_LENGTH_RST = 6'd32;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LEN_REJECT = 2'd2;

    // one finished frame handed from the parser to the readout sequencer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   frame_id;
        logic [BYTE_W-1:0]   check;
        logic [LEN_W-1:0]    length;
    } job_t;

    // body buffer write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } buf_wr_t;

    // back pressure seen by the parser
    typedef struct packed {
        logic queue_full;
        logic queue_empty;
        logic back_busy;
    } flow_t;

endpackage : xcfr_pkg
`default_nettype wire

### rtl/xcfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfr_front
// Byte parser: hunts for the start byte, checks the length, stores the body,
// accumulates the xor and queues one request per finished frame.
// ----------------------------------------------------------------------------
module xcfr_front
    import xcfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [BYTE_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire flow_t             flow,
    output logic                   push,
    output job_t                   push_job,
    output buf_wr_t                buf_wr
);

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    logic [BYTE_W-1:0]    start_byte_reg;
    logic [CFG_LEN_W-1:0] max_length_reg;
    logic [1:0]           phase_reg, phase_next;
    logic [LEN_W-1:0]     frame_length_reg, frame_length_next;
    logic [LEN_W-1:0]     byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]    running_xor_reg, running_xor_next;
    logic [BYTE_W-1:0]    frame_id_reg, frame_id_next;

    logic                 accept;
    logic [BYTE_W-1:0]    limit;
    logic                 len_bad;
    logic [LEN_W-1:0]     count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            max_length_reg <= MAX_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_BYTE: start_byte_reg <= cfg_data;
                REG_MAX_LENGTH: max_length_reg <= cfg_data[CFG_LEN_W-1:0];
                default:        start_byte_reg <= start_byte_reg;
            endcase
        end
    end

    // body bytes wait until the previous frame has been read out of the buffer
    always_comb
    begin
        in_stall = 1'b0;
        case (phase_reg)
            PH_BODY:  in_stall = flow.back_busy || !flow.queue_empty;
            PH_LEN:   in_stall = flow.queue_full;
            PH_CHECK: in_stall = flow.queue_full;
            default:  in_stall = 1'b0;
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        if (max_length_reg > CFG_LEN_W'(MAX_LEN))
            limit = BYTE_W'(MAX_LEN);
        else
            limit = BYTE_W'(max_length_reg);
    end

    assign len_bad   = (rx_byte == '0) || (rx_byte > limit);
    assign count_inc = byte_count_reg + LEN_W'(1);

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        byte_count_next   = byte_count_reg;
        running_xor_next  = running_xor_reg;
        frame_id_next     = frame_id_reg;
        push              = 1'b0;
        push_job          = '0;
        buf_wr.en         = 1'b0;
        buf_wr.addr       = byte_count_reg[ADDR_W-1:0];
        buf_wr.data       = rx_byte;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_byte_reg)
                        phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (len_bad)
                    begin
                        push            = 1'b1;
                        push_job.status = ST_LEN_REJECT;
                        phase_next      = PH_HUNT;
                    end
                    else
                    begin
                        frame_length_next = rx_byte[LEN_W-1:0];
                        byte_count_next   = '0;
                        running_xor_next  = '0;
                        phase_next        = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    buf_wr.en        = 1'b1;
                    running_xor_next = running_xor_reg ^ rx_byte;
                    byte_count_next  = count_inc;
                    if (byte_count_reg == '0)
                        frame_id_next = rx_byte;
                    if (count_inc >= frame_length_reg)
                        phase_next = PH_CHECK;
                end
                default:
                begin
                    push           = 1'b1;
                    push_job.check = running_xor_reg;
                    phase_next     = PH_HUNT;
                    if (rx_byte != running_xor_reg)
                        push_job.status = ST_MISMATCH;
                    else
                    begin
                        push_job.status   = ST_OK;
                        push_job.frame_id = frame_id_reg;
                        push_job.length   = frame_length_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            frame_length_reg <= '0;
            byte_count_reg   <= '0;
            running_xor_reg  <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_count_reg   <= byte_count_next;
            running_xor_reg  <= running_xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_id_reg <= frame_id_next;
    end

endmodule : xcfr_front
`default_nettype wire

### rtl/xcfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfr_queue
// Two entry queue of frame requests between parser and readout.
// ----------------------------------------------------------------------------
module xcfr_queue
    import xcfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      full,
    output logic      empty
);

    localparam int DEPTH = 2;

    job_t       entry_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = ~wr_ptr_reg;
        if (do_pop)
            rd_ptr_next = ~rd_ptr_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule : xcfr_queue
`default_nettype wire

### rtl/xcfr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfr_back
// Readout sequencer: owns the body buffer and turns each queued frame
// request into its results, fetching and emitting one payload byte at a time.
// ----------------------------------------------------------------------------
module xcfr_back
    import xcfr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire buf_wr_t             buf_wr,
    input  wire job_t                head,
    input  wire logic                empty,
    output logic                     pop,
    output logic                     busy,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [BYTE_W-1:0]        frame_id,
    output logic [BYTE_W-1:0]        payload_byte,
    output logic                     payload_valid,
    output logic [BYTE_W-1:0]        computed_check,
    output logic                     last
);

    localparam logic [1:0] BK_IDLE  = 2'd0;
    localparam logic [1:0] BK_FETCH = 2'd1;
    localparam logic [1:0] BK_EMIT  = 2'd2;

    logic [BYTE_W-1:0]   body_mem [MAX_LEN];
    logic [BYTE_W-1:0]   rdata_reg;

    logic [1:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [BYTE_W-1:0]   id_reg, id_next;
    logic [BYTE_W-1:0]   check_reg, check_next;
    logic [LEN_W-1:0]    len_reg, len_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0]   frame_id_reg, frame_id_next;
    logic [BYTE_W-1:0]   payload_reg, payload_next;
    logic                pvalid_reg, pvalid_next;
    logic [BYTE_W-1:0]   ocheck_reg, ocheck_next;
    logic                last_reg, last_next;

    logic                out_free;
    logic                single;
    logic                final_idx;

    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
            body_mem[buf_wr.addr] <= buf_wr.data;
        rdata_reg <= body_mem[idx_reg];
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign single    = (head.status != ST_OK) || (head.length <= LEN_W'(1));
    assign final_idx = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
    assign busy      = (state_reg != BK_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        id_next        = id_reg;
        check_next     = check_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        frame_id_next  = frame_id_reg;
        payload_next   = payload_reg;
        pvalid_next    = pvalid_reg;
        ocheck_next    = ocheck_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    if (single)
                    begin
                        if (out_free)
                        begin
                            pop            = 1'b1;
                            out_valid_next = 1'b1;
                            status_next    = head.status;
                            frame_id_next  = head.frame_id;
                            payload_next   = '0;
                            pvalid_next    = 1'b0;
                            ocheck_next    = head.check;
                            last_next      = 1'b1;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        id_next    = head.frame_id;
                        check_next = head.check;
                        len_next   = head.length;
                        idx_next   = ADDR_W'(1);
                        state_next = BK_FETCH;
                    end
                end
            end
            BK_FETCH:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    frame_id_next  = id_reg;
                    payload_next   = rdata_reg;
                    pvalid_next    = 1'b1;
                    ocheck_next    = check_reg;
                    last_next      = final_idx;
                    if (final_idx)
                        state_next = BK_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = BK_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        check_reg    <= check_next;
        len_reg      <= len_next;
        status_reg   <= status_next;
        frame_id_reg <= frame_id_next;
        payload_reg  <= payload_next;
        pvalid_reg   <= pvalid_next;
        ocheck_reg   <= ocheck_next;
        last_reg     <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign frame_id       = frame_id_reg;
    assign payload_byte   = payload_reg;
    assign payload_valid  = pvalid_reg;
    assign computed_check = ocheck_reg;
    assign last           = last_reg;

endmodule : xcfr_back
`default_nettype wire

### rtl/xor_checked_frame_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// single results (reject, mismatch, id-only) go from the closing byte through the
// request queue to the output registers; payload results also wait on a buffer read
// throughput: one byte per cycle for header and check bytes while the queue is not
// full; each payload result waits for its own registered read of the body buffer
// body bytes of the next frame stall until the previous frame is read out
// reset: control and config return to defaults at once; the body buffer is not cleared
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_top
// Deframer for start / length / body / xor check byte frames.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver_top
    import xcfr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [BYTE_W-1:0]   cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [BYTE_W-1:0]   rx_byte,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [BYTE_W-1:0]        frame_id,
    output logic [BYTE_W-1:0]        payload_byte,
    output logic                     payload_valid,
    output logic [BYTE_W-1:0]        computed_check,
    output logic                     last
);

    flow_t   flow;
    logic    push;
    job_t    push_job;
    buf_wr_t buf_wr;
    logic    pop;
    job_t    head;
    logic    q_full;
    logic    q_empty;
    logic    back_busy;

    assign flow.queue_full  = q_full;
    assign flow.queue_empty = q_empty;
    assign flow.back_busy   = back_busy;

    xcfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .flow     (flow),
        .push     (push),
        .push_job (push_job),
        .buf_wr   (buf_wr)
    );

    xcfr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head    (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    xcfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .buf_wr        (buf_wr),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .busy          (back_busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .frame_id      (frame_id),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .computed_check(computed_check),
        .last          (last)
    );

endmodule : xor_checked_frame_receiver_top
`default_nettype wire

### test/xcfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfr_checker
// Watches the byte, result and register ports of the frame receiver, keeps its
// own deframer state, and compares every accepted result in order against the
// results that the accepted bytes call for.
// ----------------------------------------------------------------------------
module xcfr_checker
    import xcfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [BYTE_W-1:0]   cfg_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [BYTE_W-1:0]   frame_id,
    input  logic [BYTE_W-1:0]   payload_byte,
    input  logic                payload_valid,
    input  logic [BYTE_W-1:0]   computed_check,
    input  logic                last,
    output int                  fault_count,
    output int                  results_owed,
    output logic                hunting
);

    typedef enum logic [1:0] {
        HUNT,
        TAKE_LENGTH,
        TAKE_BODY,
        TAKE_CHECK
    } deframe_phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   frame_id;
        logic [BYTE_W-1:0]   payload_byte;
        logic                payload_valid;
        logic [BYTE_W-1:0]   computed_check;
        logic                last;
    } frame_result_t;

    logic [BYTE_W-1:0]    start_byte_q;
    logic [CFG_LEN_W-1:0] max_length_q;
    deframe_phase_t       phase;
    logic [5:0]           frame_len;
    logic [5:0]           body_count;
    logic [BYTE_W-1:0]    body_xor;
    logic [BYTE_W-1:0]    body_mem [MAX_LEN];

    frame_result_t awaited_results [$];
    int            mismatch_total = 0;

    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        int            limit;
        int            i;
        frame_result_t r;
        r = '0;
        case (phase)
            HUNT:
            begin
                if (b == start_byte_q)
                    phase = TAKE_LENGTH;
            end
            TAKE_LENGTH:
            begin
                // limit is taken at the length byte, clamped to the buffer size
                limit = (max_length_q > MAX_LEN) ? MAX_LEN : int'(max_length_q);
                if (b == 0 || int'(b) > limit)
                begin
                    r.status = ST_LEN_REJECT;
                    r.last   = 1'b1;
                    awaited_results.push_back(r);
                    phase = HUNT;
                end
                else
                begin
                    frame_len  = b[5:0];
                    body_count = '0;
                    body_xor   = '0;
                    phase      = TAKE_BODY;
                end
            end
            TAKE_BODY:
            begin
                if (body_count < MAX_LEN)
                    body_mem[body_count[ADDR_W-1:0]] = b;
                body_xor   = body_xor ^ b;
                body_count = body_count + 6'd1;
                if (body_count >= frame_len)
                    phase = TAKE_CHECK;
            end
            default:
            begin
                phase            = HUNT;
                r.computed_check = body_xor;
                r.last           = 1'b1;
                if (b != body_xor)
                begin
                    r.status = ST_MISMATCH;
                    awaited_results.push_back(r);
                end
                else if (frame_len <= 1)
                begin
                    r.status   = ST_OK;
                    r.frame_id = body_mem[0];
                    awaited_results.push_back(r);
                end
                else
                begin
                    r.status        = ST_OK;
                    r.frame_id      = body_mem[0];
                    r.payload_valid = 1'b1;
                    for (i = 1; i < frame_len && i < MAX_LEN; i++)
                    begin
                        r.payload_byte = body_mem[ADDR_W'(i)];
                        r.last         = (i + 1 == frame_len);
                        awaited_results.push_back(r);
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            start_byte_q = START_BYTE_RST;
            max_length_q = MAX_LENGTH_RST;
            phase        = HUNT;
            frame_len    = '0;
            body_count   = '0;
            body_xor     = '0;
            awaited_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_START_BYTE)
                    start_byte_q = cfg_data;
                else
                    max_length_q = cfg_data[CFG_LEN_W-1:0];
            end
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with none outstanding: status %0d id %0h byte %0h",
                           status, frame_id, payload_byte);
                    mismatch_total++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("frame_id", want.frame_id, frame_id);
                    check_field("payload_byte", want.payload_byte, payload_byte);
                    check_field("payload_valid", want.payload_valid, payload_valid);
                    check_field("computed_check", want.computed_check, computed_check);
                    check_field("last", want.last, last);
                end
            end
        end
        fault_count  <= mismatch_total;
        results_owed <= awaited_results.size();
        hunting      <= (phase == HUNT);
    end

endmodule : xcfr_checker

### test/xor_checked_frame_receiver_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_top_tb
// Feeds the frame receiver a short list of edge-case frames, then random
// streams of good, corrupted, rejected and cut-off frames under several start
// byte and length limit settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver_top_tb;
    import xcfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic                cfg_index     = REG_START_BYTE;
    logic [BYTE_W-1:0]   cfg_data      = '0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [BYTE_W-1:0]   rx_byte       = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   frame_id;
    logic [BYTE_W-1:0]   payload_byte;
    logic                payload_valid;
    logic [BYTE_W-1:0]   computed_check;
    logic                last;
    int                  fault_count;
    int                  results_owed;
    logic                hunting;

    int                  sent_total   = 0;
    int                  frame_items  = 0;
    bit                  sender_quiet = 1'b0;
    logic [BYTE_W-1:0]   cur_start    = START_BYTE_RST;
    int                  cur_limit    = MAX_LEN;

    xor_checked_frame_receiver_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .frame_id       (frame_id),
        .payload_byte   (payload_byte),
        .payload_valid  (payload_valid),
        .computed_check (computed_check),
        .last           (last)
    );

    xcfr_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .frame_id       (frame_id),
        .payload_byte   (payload_byte),
        .payload_valid  (payload_valid),
        .computed_check (computed_check),
        .last           (last),
        .fault_count    (fault_count),
        .results_owed   (results_owed),
        .hunting        (hunting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // valid is left high after a request so back-to-back bytes need no extra edge
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit counted);
        int gap;
        if (sent_total % 32 == 0)
            sender_quiet = ($urandom_range(0, 2) == 0);
        gap = sender_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        sent_total++;
        if (counted)
            frame_items++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        // readout may still be busy after the last result
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [BYTE_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] start, input logic [BYTE_W-1:0] max_raw);
        write_reg(REG_START_BYTE, start);
        write_reg(REG_MAX_LENGTH, max_raw);
        cur_start = start;
        cur_limit = (max_raw[CFG_LEN_W-1:0] > MAX_LEN) ? MAX_LEN : int'(max_raw[CFG_LEN_W-1:0]);
    endtask

    // non-start bytes run any open frame to its end and back to hunting
    task automatic close_open_frame();
        in_valid <= 1'b0;
        @(posedge clk);
        while (!hunting)
        begin
            send_byte(~cur_start, 1'b0);
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic random_frames(input int target);
        int                kind;
        int                len;
        int                n_body;
        int                stop_at;
        int                i;
        bit                cut_short;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] x;
        stop_at = frame_items + target;
        while (frame_items < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind >= 95)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == cur_start)
                    b = b ^ 8'h01;
                send_byte(b, 1'b0);
            end
            else if (kind >= 83 || cur_limit == 0)
            begin
                send_byte(cur_start, 1'b1);
                case ($urandom_range(0, 3))
                    0:       b = 8'h00;
                    1:       b = 8'(cur_limit + 1);
                    2:       b = 8'($urandom_range(64, 255));
                    default: b = 8'($urandom_range(cur_limit + 1, 255));
                endcase
                send_byte(b, 1'b1);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       len = 1;
                    1:       len = cur_limit;
                    2, 3:    len = $urandom_range(1, cur_limit);
                    default: len = $urandom_range(1, (cur_limit < 6) ? cur_limit : 6);
                endcase
                cut_short = (kind >= 77 && len > 1);
                n_body    = cut_short ? $urandom_range(0, len - 1) : len;
                send_byte(cur_start, 1'b1);
                send_byte(8'(len), 1'b1);
                x = '0;
                for (i = 0; i < n_body; i++)
                begin
                    b = ($urandom_range(0, 15) == 0) ? cur_start : 8'($urandom_range(0, 255));
                    x = x ^ b;
                    send_byte(b, 1'b1);
                end
                if (!cut_short)
                begin
                    if (kind >= 65)
                        x = x ^ (8'h01 << $urandom_range(0, 7));
                    send_byte(x, 1'b1);
                end
            end
        end
    endtask

    initial
    begin : stimulus
        logic [BYTE_W-1:0] opening [26];
        // rejects: zero, one over the limit, wraps to one, far above 63;
        // id-only extremes, mismatch, start value inside the body and as check
        opening = '{8'h00, 8'hFF,
                    START_BYTE_RST, 8'd0,  START_BYTE_RST, 8'd33,
                    START_BYTE_RST, 8'd65, START_BYTE_RST, 8'hFF,
                    START_BYTE_RST, 8'd1,  8'hFF, 8'hFF,
                    START_BYTE_RST, 8'd1,  8'h00, 8'h01,
                    START_BYTE_RST, 8'd3,  START_BYTE_RST, 8'h00, 8'hFF, 8'h5A,
                    START_BYTE_RST, 8'd2};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (opening[i])
            send_byte(opening[i], 1'b1);
        send_byte(8'h25, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(START_BYTE_RST, 1'b1);
        wait_idle();

        random_frames(45);
        close_open_frame();
        wait_idle();

        // only id-only frames pass
        set_config(8'hFF, 8'h01);
        random_frames(20);
        close_open_frame();
        wait_idle();

        // limit above the buffer size clamps
        set_config(8'h00, 8'h3F);
        random_frames(40);
        close_open_frame();
        wait_idle();

        // zero limit rejects every length
        set_config(8'($urandom_range(1, 254)), 8'h00);
        random_frames(15);
        close_open_frame();
        wait_idle();

        // upper data bits are not part of the limit
        set_config(START_BYTE_RST, 8'hE0);
        random_frames(35);
        close_open_frame();
        wait_idle();

        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_frames(35);
        close_open_frame();
        wait_idle();

        repeat (20) @(posedge clk);
        if (results_owed != 0)
            $error("%0d results never arrived", results_owed);
        if (fault_count == 0 && results_owed == 0)
            $display("xor_checked_frame_receiver_top_tb passed");
        else
            $display("xor_checked_frame_receiver_top_tb failed");
        $finish;
    end

    initial
    begin : result_sink
        int stall_cycles;
        int taken;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        forever
        begin
            if (taken % 24 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            stall_cycles = quiet ? 0 : $urandom_range(0, 11);
            // one long hold so the receiver backs up into the byte input
            if (taken == 30)
                stall_cycles = LONG_HOLD;
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("xor_checked_frame_receiver_top_tb failed");
                $finish;
            end
        end
    end

endmodule : xor_checked_frame_receiver_top_tb

### xor_checked_frame_receiver_top.f
rtl/xcfr_pkg.sv
rtl/xcfr_front.sv
rtl/xcfr_queue.sv
rtl/xcfr_back.sv
rtl/xor_checked_frame_receiver_top.sv
test/xcfr_checker.sv
test/xor_checked_frame_receiver_top_tb.sv
